// File: rtl/core/wedc_pkg.sv
package wedc_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int CHAR_W      = 8;
  localparam int DIST_W      = 16;
  localparam int CNT_W       = 32;
  localparam int PAT_W       = 64;
  localparam int LEN_W       = 5;
  localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_W       = DIST_W + 2 * CNT_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN  = 2'd2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

  // One text byte travelling down the row of cells.
  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [CHAR_W-1:0] chr;
    logic [DIST_W-1:0] diag;
    logic [DIST_W-1:0] left;
    logic [DIST_W-1:0] sel;
  } wedc_token_t;

  function automatic logic [DIST_W-1:0] inc_sat(input logic [DIST_W-1:0] v);
    return (v == DIST_MAX) ? DIST_MAX : v + 1'b1;
  endfunction

endpackage

// File: rtl/core/wedc_head.sv
module wedc_head import wedc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              accept,
  input  logic [CHAR_W-1:0] chr,
  input  logic              last,
  output wedc_token_t       tok
);

  logic [DIST_W-1:0] row_index;
  logic              at_word_start;
  logic [DIST_W-1:0] base;

  // A new word starts its row at zero.
  assign base = at_word_start ? '0 : row_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid     <= 1'b0;
      at_word_start <= 1'b1;
      row_index     <= '0;
    end else if (en) begin
      tok.valid <= accept;
      if (accept) begin
        at_word_start <= last;
        row_index     <= inc_sat(base);
        tok.first     <= at_word_start;
        tok.last      <= last;
        tok.chr       <= chr;
        tok.diag      <= base;
        tok.left      <= inc_sat(base);
        // With an empty pattern the distance is the word length.
        tok.sel       <= inc_sat(base);
      end
    end
  end

endmodule

// File: rtl/core/wedc_cell.sv
module wedc_cell import wedc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [IDX_W-1:0]  idx,
  input  logic [CHAR_W-1:0] pat_char,
  input  logic [LEN_W-1:0]  pat_len,
  input  wedc_token_t       tok_in,
  output wedc_token_t       tok_out
);

  logic [DIST_W-1:0] row_dist;
  logic [DIST_W-1:0] up;
  logic [DIST_W-1:0] best;
  logic [DIST_W-1:0] cost;

  assign up = tok_in.first ? DIST_W'(idx) + 1'b1 : row_dist;

  always_comb begin
    best = tok_in.diag;
    if (up < best) best = up;
    if (tok_in.left < best) best = tok_in.left;
    cost = (tok_in.chr == pat_char) ? tok_in.diag : inc_sat(best);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out.valid <= tok_in.valid;
      if (tok_in.valid) begin
        row_dist      <= cost;
        tok_out.first <= tok_in.first;
        tok_out.last  <= tok_in.last;
        tok_out.chr   <= tok_in.chr;
        tok_out.diag  <= up;
        tok_out.left  <= cost;
        tok_out.sel   <= (pat_len == LEN_W'(idx) + 1'b1) ? cost : tok_in.sel;
      end
    end
  end

endmodule

// File: rtl/core/wedc_tail.sv
module wedc_tail import wedc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  wedc_token_t      tok,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [OUT_W-1:0] out_data
);

  logic [CNT_W-1:0] word_count;
  logic [CNT_W-1:0] distance_sum;
  logic [CNT_W:0]   sum_wide;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] sum_next;
  logic             take;

  assign take       = en && tok.valid && tok.last;
  assign sum_wide   = {1'b0, distance_sum} + (CNT_W + 1)'(tok.sel);
  assign sum_next   = sum_wide[CNT_W] ? CNT_MAX : sum_wide[CNT_W-1:0];
  assign count_next = (word_count == CNT_MAX) ? CNT_MAX : word_count + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      word_count   <= '0;
      distance_sum <= '0;
    end else begin
      if (take) begin
        out_valid    <= 1'b1;
        word_count   <= count_next;
        distance_sum <= sum_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= {sum_next, count_next, tok.sel};
    end
  end

endmodule

// File: rtl/core/word_edit_distance_scorer.sv
// A text byte with tlast set gives its result on m_tvalid through the entry stage (at the
// transfer edge), one stage per pattern cell and one output register.
// Throughput: one text byte per cycle; the row of cells is a skewed pipeline, so the only
// stall is a finished word meeting a result that has not been taken yet.
// Configuration writes are taken only when no byte is inside the row of cells.
// Reset (rst, synchronous) empties the pipeline, clears the counters and the pattern.
module word_edit_distance_scorer import wedc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [CHAR_W-1:0]    s_tdata,   // [7:0] text_char
  input  logic                 s_tlast,   // word_last
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [OUT_W-1:0]     m_tdata,   // [15:0] word_distance, [47:16] words_counted,
                                          // [79:48] distance_total
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_data
);

  logic [PAT_W-1:0] pat_low;
  logic [PAT_W-1:0] pat_high;
  logic [LEN_W-1:0] pat_len;
  logic [LEN_W-1:0] len_eff;
  logic             en;
  logic [MAX_PATTERN:0] busy;
  wedc_token_t      chain [MAX_PATTERN+1];

  // Only a finished word can be blocked by a waiting result.
  assign en        = !(chain[MAX_PATTERN].valid && chain[MAX_PATTERN].last &&
                       m_tvalid && !m_tready);
  assign s_tready  = en;
  assign cfg_ready = !(|busy);
  assign len_eff   = (pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_low  <= '0;
      pat_high <= '0;
      pat_len  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAT_LOW:  pat_low  <= cfg_data;
        REG_PAT_HIGH: pat_high <= cfg_data;
        REG_PAT_LEN:  pat_len  <= cfg_data[LEN_W-1:0];
        default:      ;
      endcase
    end
  end

  wedc_head u_head (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .accept (s_tvalid),
    .chr    (s_tdata),
    .last   (s_tlast),
    .tok    (chain[0])
  );

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [CHAR_W-1:0] pat_char;
    if (j < PAT_W / CHAR_W) begin : g_low
      assign pat_char = pat_low[CHAR_W*j +: CHAR_W];
    end else begin : g_high
      assign pat_char = pat_high[CHAR_W*(j - PAT_W / CHAR_W) +: CHAR_W];
    end
    assign busy[j] = chain[j].valid;

    wedc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .idx      (IDX_W'(j)),
      .pat_char (pat_char),
      .pat_len  (len_eff),
      .tok_in   (chain[j]),
      .tok_out  (chain[j+1])
    );
  end
  assign busy[MAX_PATTERN] = chain[MAX_PATTERN].valid;

  wedc_tail u_tail (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .tok       (chain[MAX_PATTERN]),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata)
  );

endmodule

// File: rtl/core/wedc_checker.sv
module wedc_checker import wedc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [OUT_W-1:0]     m_tdata,
  input logic                 cfg_ready
);

  // No result can be shown in the cycle after reset.
  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
      m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Every result counts at least its own word.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> m_tdata[DIST_W +: CNT_W] != '0)
    else $error("result with zero word count");

  // The running total includes the current distance, saturation included.
  a_total_covers: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> m_tdata[DIST_W+CNT_W +: CNT_W] >= CNT_W'(m_tdata[DIST_W-1:0]))
    else $error("distance total below word distance");

  // A byte in flight keeps the configuration port closed.
  a_cfg_closed: assert property (@(posedge clk) disable iff (rst)
      s_tvalid && s_tready |=> !cfg_ready)
    else $error("configuration open with byte in flight");

endmodule

bind word_edit_distance_scorer wedc_checker u_wedc_checker (.*);
